@@ rtl/dtwca_pkg.sv @@
// dtwca_pkg: shared widths, register codes, reset values and types for the
// dtw cost accumulation block. No dependencies.

package dtwca_pkg;

    localparam int unsigned DIST_W      = 16;
    localparam int unsigned COST_W      = 32;
    localparam int unsigned STEP_W      = 2;
    localparam int unsigned WEIGHT_W    = 12;
    localparam int unsigned PROD_W      = WEIGHT_W + DIST_W;
    localparam int unsigned ROW_W       = 16;
    localparam int unsigned RULE_COUNT  = 4;
    localparam int unsigned OUT_TDATA_W = 40;

    localparam int unsigned CFG_COLS_W  = 11;
    localparam int unsigned CFG_STEPS_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_IDX_W   = 3;

    localparam int unsigned MAX_COLUMNS_DEF = 1024;
    localparam int unsigned MAX_STEPS_DEF   = 4;
    localparam int unsigned ROWS_KEPT_DEF   = 4;

    localparam logic [COST_W-1:0] INFINITY = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_3  = 3'd5;

    localparam logic [CFG_COLS_W-1:0]  COLS_RST   = 11'd1024;
    localparam logic [CFG_STEPS_W-1:0] STEPS_RST  = 3'd3;
    localparam logic [CFG_DATA_W-1:0]  RULE_0_RST = 16'h1005;
    localparam logic [CFG_DATA_W-1:0]  RULE_1_RST = 16'h1004;
    localparam logic [CFG_DATA_W-1:0]  RULE_2_RST = 16'h1001;
    localparam logic [CFG_DATA_W-1:0]  RULE_3_RST = 16'h0000;

    localparam logic [STEP_W-1:0] CORNER_STEP = 2'd1;

    // same bit layout as the step rule register
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [1:0]          dc;
        logic [1:0]          dr;
    } t_rule;

    typedef struct packed {
        logic              win;
        logic [COST_W-1:0] cand;
        logic [STEP_W-1:0] idx;
    } t_eval;

endpackage

@@ rtl/dtwca_cfg.sv @@
// dtwca_cfg: configuration registers and their clamped working values.
// Depends on dtwca_pkg.

module dtwca_cfg
    import dtwca_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int unsigned MAX_STEPS   = MAX_STEPS_DEF,
    localparam int unsigned CNT_W = $clog2(MAX_COLUMNS + 1),
    localparam int unsigned EW    = (CNT_W > CFG_COLS_W) ? CNT_W : CFG_COLS_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic [EW-1:0]          o_cols_active,
    output logic [CFG_STEPS_W-1:0] o_steps_active,
    output t_rule [RULE_COUNT-1:0] o_rules
);

    localparam int unsigned STEP_CAP = (MAX_STEPS < RULE_COUNT) ? MAX_STEPS : RULE_COUNT;
    localparam logic [EW-1:0] MAXC = EW'(MAX_COLUMNS);

    logic [CFG_COLS_W-1:0]  r_cols;
    logic [CFG_STEPS_W-1:0] r_steps;
    t_rule [RULE_COUNT-1:0] r_rule;
    logic [EW-1:0]          cols_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols    <= COLS_RST;
            r_steps   <= STEPS_RST;
            r_rule[0] <= RULE_0_RST;
            r_rule[1] <= RULE_1_RST;
            r_rule[2] <= RULE_2_RST;
            r_rule[3] <= RULE_3_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COLUMNS: r_cols    <= i_cfg_data[CFG_COLS_W-1:0];
                CFG_STEPS:   r_steps   <= i_cfg_data[CFG_STEPS_W-1:0];
                CFG_RULE_0:  r_rule[0] <= i_cfg_data;
                CFG_RULE_1:  r_rule[1] <= i_cfg_data;
                CFG_RULE_2:  r_rule[2] <= i_cfg_data;
                CFG_RULE_3:  r_rule[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cols_ext = EW'(r_cols);

    always_comb begin
        if (r_cols == '0) begin
            o_cols_active = EW'(1);
        end else if (cols_ext > MAXC) begin
            o_cols_active = MAXC;
        end else begin
            o_cols_active = cols_ext;
        end
        if (r_steps > CFG_STEPS_W'(STEP_CAP)) begin
            o_steps_active = CFG_STEPS_W'(STEP_CAP);
        end else begin
            o_steps_active = r_steps;
        end
    end

    assign o_rules = r_rule;

endmodule

@@ rtl/dtwca_cost_mem.sv @@
// dtwca_cost_mem: ring of stored accumulated costs, one write port and one
// registered read port. Depends on dtwca_pkg.

module dtwca_cost_mem
    import dtwca_pkg::*;
#(
    parameter int unsigned DEPTH = ROWS_KEPT_DEF * MAX_COLUMNS_DEF,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [COST_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [COST_W-1:0] o_rdata
);

    logic [COST_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/dtwca_step_unit.sv @@
// dtwca_step_unit: shared step evaluator. issue stage checks one rule, forms
// the read address and the weighted distance; eval stage adds, saturates and
// compares against the best so far. Depends on dtwca_pkg.

module dtwca_step_unit
    import dtwca_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int unsigned ROWS_KEPT   = ROWS_KEPT_DEF,
    localparam int unsigned COL_W  = $clog2(MAX_COLUMNS),
    localparam int unsigned RING_W = $clog2(ROWS_KEPT),
    localparam int unsigned ADDR_W = $clog2(ROWS_KEPT * MAX_COLUMNS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_issue,
    input  t_rule             i_rule,
    input  logic [STEP_W-1:0] i_idx,
    input  logic [DIST_W-1:0] i_dist,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [COL_W-1:0]  i_col,
    input  logic [RING_W-1:0] i_ring,
    input  logic [COST_W-1:0] i_rdata,
    input  logic [COST_W-1:0] i_best,
    output logic [ADDR_W-1:0] o_raddr,
    output logic [ADDR_W-1:0] o_waddr,
    output t_eval             o_eval
);

    localparam int unsigned CX = COL_W + 2;
    localparam logic [3:0] RK4 = 4'(ROWS_KEPT);

    logic [3:0]        dr4;
    logic [3:0]        ring4;
    logic [3:0]        rr4;
    logic [COL_W-1:0]  src_col;
    logic              qualify;
    logic [PROD_W-1:0] prod;
    logic [COST_W:0]   sum;
    logic [COST_W-1:0] cand;

    logic              r_vld;
    logic [PROD_W-1:0] r_prod;
    logic [STEP_W-1:0] r_idx;

    assign dr4   = {2'b00, i_rule.dr};
    assign ring4 = 4'(i_ring);

    always_comb begin
        qualify = !(i_rule.dr == 2'd0 && i_rule.dc == 2'd0)
                && (dr4 < RK4)
                && (i_row >= ROW_W'(i_rule.dr))
                && (CX'(i_col) >= CX'(i_rule.dc));
        // ring slot of the source row, wrapped once
        if (ring4 >= dr4) begin
            rr4 = ring4 - dr4;
        end else begin
            rr4 = ring4 + RK4 - dr4;
        end
    end

    // source column, only used when the rule qualifies
    assign src_col = i_col - COL_W'(i_rule.dc);

    assign o_raddr = ADDR_W'(ADDR_W'(rr4) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(src_col));
    assign o_waddr = ADDR_W'(ADDR_W'(i_ring) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(i_col));

    assign prod = PROD_W'(i_rule.weight) * PROD_W'(i_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_issue && qualify;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        r_idx  <= i_idx;
    end

    always_comb begin
        sum  = (COST_W + 1)'(i_rdata) + (COST_W + 1)'(r_prod[PROD_W-1:8]);
        cand = sum[COST_W] ? INFINITY : sum[COST_W-1:0];
        o_eval.win  = r_vld && (cand < i_best);
        o_eval.cand = cand;
        o_eval.idx  = r_idx;
    end

endmodule

@@ rtl/dtw_cost_accumulate_core.sv @@
// dtw_cost_accumulate_core: top level, cell position tracking, rule sequencer
// and output register. Depends on dtwca_pkg, dtwca_cfg, dtwca_cost_mem, dtwca_step_unit.
//
//   channel  | direction | signals                      | contents
//   ---------+-----------+------------------------------+----------------------------------
//   s_axis   | in        | tvalid tready tdata tuser    | tdata distance, tuser start_matrix
//   m_axis   | out       | tvalid tready tdata          | tdata accumulated_cost, best_step
//   cfg      | in        | i_cfg_we i_cfg_index data    | register writes, no read-back
//
// after an accepted beat the sequencer issues each active step rule, then drains
// and writes; cell (0,0) or zero rules go straight to write. one rule per cycle
// goes through the shared step unit, bounded by the single cost memory read port.
// reset clears position, last step and handshake state; the cost memory holds
// no reset value. a stalled output holds the sequencer in its write state.

module dtw_cost_accumulate_core
    import dtwca_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int unsigned MAX_STEPS   = MAX_STEPS_DEF,
    parameter int unsigned ROWS_KEPT   = ROWS_KEPT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [DIST_W-1:0]      s_axis_tdata,   // [15:0] distance
    input  logic [0:0]             s_axis_tuser,   // [0] start_matrix
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] accumulated_cost, [33:32] best_step
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int unsigned COL_W  = $clog2(MAX_COLUMNS);
    localparam int unsigned RING_W = $clog2(ROWS_KEPT);
    localparam int unsigned DEPTH  = ROWS_KEPT * MAX_COLUMNS;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(MAX_COLUMNS + 1);
    localparam int unsigned EW     = (CNT_W > CFG_COLS_W) ? CNT_W : CFG_COLS_W;
    localparam logic [RING_W-1:0] RING_LAST = RING_W'(ROWS_KEPT - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    logic [EW-1:0]          cols_active;
    logic [CFG_STEPS_W-1:0] steps_active;
    t_rule [RULE_COUNT-1:0] rules;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_k, n_k;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [RING_W-1:0] r_ring, n_ring;
    logic [COST_W-1:0] r_best, n_best;
    logic [STEP_W-1:0] r_last, n_last;
    logic              r_out_valid, n_out_valid;
    logic [COST_W-1:0] r_out_cost, n_out_cost;
    logic [STEP_W-1:0] r_out_step, n_out_step;

    logic              accept;
    logic              wr_fire;
    logic              issue;
    logic              last_rule;
    logic [ROW_W-1:0]  e_row;
    logic [COL_W-1:0]  e_col;
    logic [RING_W-1:0] e_ring;
    logic [RING_W-1:0] ring_inc;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic [COST_W-1:0] rdata;
    t_eval             eval;

    dtwca_cfg #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_STEPS   (MAX_STEPS)
    ) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_cols_active  (cols_active),
        .o_steps_active (steps_active),
        .o_rules        (rules)
    );

    dtwca_step_unit #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .ROWS_KEPT   (ROWS_KEPT)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (issue),
        .i_rule  (rules[r_k]),
        .i_idx   (r_k),
        .i_dist  (r_dist),
        .i_row   (r_row),
        .i_col   (r_col),
        .i_ring  (r_ring),
        .i_rdata (rdata),
        .i_best  (r_best),
        .o_raddr (raddr),
        .o_waddr (waddr),
        .o_eval  (eval)
    );

    dtwca_cost_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_fire),
        .i_waddr (waddr),
        .i_wdata (r_best),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign wr_fire       = (r_state == S_WRITE) && (!r_out_valid || m_axis_tready);
    assign issue         = (r_state == S_ISSUE);
    assign last_rule     = (CFG_STEPS_W'(r_k) + CFG_STEPS_W'(1)) == steps_active;
    assign ring_inc      = (r_ring == RING_LAST) ? '0 : RING_W'(r_ring + 1'b1);

    // position of the arriving cell
    always_comb begin
        if (s_axis_tuser[0]) begin
            e_row  = '0;
            e_col  = '0;
            e_ring = '0;
        end else if (EW'(r_col) >= cols_active) begin
            e_row  = r_row + 1'b1;
            e_col  = '0;
            e_ring = ring_inc;
        end else begin
            e_row  = r_row;
            e_col  = r_col;
            e_ring = r_ring;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_dist      = r_dist;
        n_row       = r_row;
        n_col       = r_col;
        n_ring      = r_ring;
        n_best      = r_best;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_cost  = r_out_cost;
        n_out_step  = r_out_step;

        if (eval.win) begin
            n_best = eval.cand;
            n_last = eval.idx;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_dist = s_axis_tdata;
                    n_row  = e_row;
                    n_col  = e_col;
                    n_ring = e_ring;
                    n_k    = '0;
                    if (e_row == '0 && e_col == '0) begin
                        n_best  = COST_W'(s_axis_tdata);
                        n_last  = CORNER_STEP;
                        n_state = S_WRITE;
                    end else begin
                        n_best  = INFINITY;
                        n_state = (steps_active == '0) ? S_WRITE : S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                n_k = r_k + 1'b1;
                if (last_rule) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (wr_fire) begin
                    if (EW'(r_col) + EW'(1) >= cols_active) begin
                        n_col  = '0;
                        n_row  = r_row + 1'b1;
                        n_ring = ring_inc;
                    end else begin
                        n_col = COL_W'(r_col + 1'b1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (wr_fire) begin
            n_out_valid = 1'b1;
            n_out_cost  = r_best;
            n_out_step  = r_last;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_ring      <= '0;
            r_last      <= CORNER_STEP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_row       <= n_row;
            r_col       <= n_col;
            r_ring      <= n_ring;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist     <= n_dist;
        r_best     <= n_best;
        r_out_cost <= n_out_cost;
        r_out_step <= n_out_step;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - COST_W - STEP_W)'(0), r_out_step, r_out_cost};

endmodule

@@ rtl/dtwca_checker.sv @@
// dtwca_checker: port-level checks for dtw_cost_accumulate_core, bound in below.
// Depends on dtwca_pkg.

module dtwca_checker
    import dtwca_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [DIST_W-1:0]      s_axis_tdata,
    input logic [0:0]             s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // input ready is low in the cycle after an accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted beat");

    // a new result appears together with the input side reopening
    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result shown while the sequencer is still busy");

    // pad bits above best_step stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:COST_W+STEP_W] == '0))
        else $error("output pad bits set");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output beat changed");

endmodule

bind dtw_cost_accumulate_core dtwca_checker u_dtwca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
